[design/lcf_pkg.sv]
// lcf_pkg: shared types, constants and helpers of the candle flicker engine
// depends on nothing; used by the interfaces, the update datapath and the top level
package lcf_pkg;

	// field widths
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned INIT_W  = 2;
	localparam int unsigned DRAW_W  = 7;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned CFG_W   = 8;

	// default pixel count
	localparam int unsigned PIXELS_DEF = 64;

	// configuration register indexes
	localparam logic REG_INTENSITY = 1'b0;
	localparam logic REG_SPEED     = 1'b1;

	// configuration reset values
	localparam logic [CFG_W-1:0] INTENSITY_RST = 8'd255;
	localparam logic [CFG_W-1:0] SPEED_RST     = 8'd100;

	// flicker constants
	localparam logic [LEVEL_W-1:0] LEVEL_INIT  = 8'd128;
	localparam logic [LEVEL_W-1:0] TARGET_BASE = 8'd130;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;
	localparam logic [CFG_W-1:0]   SPEED_FAST  = 8'd252;
	localparam logic [CFG_W-1:0]   SPEED_MID   = 8'd99;
	localparam logic [CFG_W-1:0]   SPEED_SLOW  = 8'd49;

	// one stored pixel entry
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] target;
		logic [LEVEL_W-1:0] step;
	} lcf_entry_t;

	localparam int unsigned ENTRY_W = $bits(lcf_entry_t);

	// random draws of one transaction
	typedef struct packed {
		logic [INIT_W-1:0] init_draw;
		logic [DRAW_W-1:0] draw_first;
		logic [DRAW_W-1:0] draw_second;
		logic [DRAW_W-1:0] draw_third;
	} lcf_draws_t;

	// fade step shift from the speed setting
	function automatic logic [2:0] shift_factor(input logic [CFG_W-1:0] sp);
		logic [2:0] f;
		if (sp > SPEED_FAST)
			f = 3'd1;
		else if (sp > SPEED_MID)
			f = 3'd2;
		else if (sp > SPEED_SLOW)
			f = 3'd3;
		else
			f = 3'd4;
		return f;
	endfunction

endpackage

[design/lcf_if.sv]
// lcf_in_if and lcf_out_if: valid/ready channels of the candle flicker engine
// depends on lcf_pkg for the field widths
interface lcf_in_if;
	logic                             valid;
	logic                             ready;
	logic [lcf_pkg::IDX_W-1:0]        pixel_index;
	logic [lcf_pkg::INIT_W-1:0]       init_draw;
	logic [lcf_pkg::DRAW_W-1:0]       draw_first;
	logic [lcf_pkg::DRAW_W-1:0]       draw_second;
	logic [lcf_pkg::DRAW_W-1:0]       draw_third;

	modport source(output valid, pixel_index, init_draw, draw_first, draw_second,
		draw_third, input ready);
	modport sink(input valid, pixel_index, init_draw, draw_first, draw_second,
		draw_third, output ready);
endinterface

interface lcf_out_if;
	logic                             valid;
	logic                             ready;
	logic [lcf_pkg::IDX_W-1:0]        pixel_out_index;
	logic [lcf_pkg::LEVEL_W-1:0]      brightness_level;

	modport source(output valid, pixel_out_index, brightness_level, input ready);
	modport sink(input valid, pixel_out_index, brightness_level, output ready);
endinterface

[design/lcf_ram.sv]
// lcf_ram: generic simple dual-port RAM, one write and one registered read port
// depends on nothing
module lcf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/lcf_tick_alu.sv]
// lcf_tick_alu: one flicker tick of a pixel entry
// depends on lcf_pkg for the entry type, constants and the shift helper
module lcf_tick_alu (
	input  lcf_pkg::lcf_entry_t          cur,
	input  lcf_pkg::lcf_draws_t          draws,
	input  logic [lcf_pkg::CFG_W-1:0]    intensity,
	input  logic [lcf_pkg::CFG_W-1:0]    speed_setting,
	output lcf_pkg::lcf_entry_t          nxt
);
	import lcf_pkg::*;

	logic               init;
	logic [LEVEL_W-1:0] lvl0, tgt0, stp0;
	logic               rising;
	logic [LEVEL_W:0]   sum;
	logic [LEVEL_W-1:0] lvl1;
	logic               reached;
	logic [6:0]         half;
	logic [5:0]         quarter;
	logic [LEVEL_W-1:0] t_pair, t_alt, t_sel, tgt_new;
	logic [LEVEL_W-1:0] dif, dif_sh;
	logic [2:0]         fac;

	// uninitialised pixel starts mid-level
	always_comb begin
		init = (cur.step == '0);
		lvl0 = init ? LEVEL_INIT : cur.level;
		tgt0 = init ? (TARGET_BASE + {{(LEVEL_W-INIT_W){1'b0}}, draws.init_draw}) : cur.target;
		stp0 = init ? {{(LEVEL_W-1){1'b0}}, 1'b1} : cur.step;
	end

	// move toward the target with saturation
	always_comb begin
		rising = (tgt0 > lvl0);
		sum    = {1'b0, lvl0} + {1'b0, stp0};
		if (rising) begin
			lvl1    = sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
			reached = (lvl1 >= tgt0);
		end else begin
			lvl1    = (lvl0 > stp0) ? (lvl0 - stp0) : '0;
			reached = (lvl1 <= tgt0);
		end
	end

	// next target from the draws, mod 256
	always_comb begin
		half    = intensity[CFG_W-1:1];
		quarter = half[6:1];
		t_pair  = {1'b0, draws.draw_first} + {1'b0, draws.draw_second};
		t_alt   = {2'b00, quarter} + {1'b0, draws.draw_third};
		t_sel   = (t_pair < {2'b00, quarter}) ? t_alt : t_pair;
		tgt_new = t_sel + ~intensity;
	end

	// fade step from the remaining distance
	always_comb begin
		fac    = shift_factor(speed_setting);
		dif    = (tgt_new > lvl1) ? (tgt_new - lvl1) : (lvl1 - tgt_new);
		dif_sh = dif >> fac;
	end

	// assemble the written-back entry
	always_comb begin
		nxt.level = lvl1;
		if (reached) begin
			nxt.target = tgt_new;
			nxt.step   = (dif_sh == '0) ? {{(LEVEL_W-1){1'b0}}, 1'b1} : dif_sh;
		end else begin
			nxt.target = tgt0;
			nxt.step   = stp0;
		end
	end

endmodule

[design/led_candle_flicker_engine_core.sv]
// led_candle_flicker_engine_core: per-pixel candle flicker with state in one RAM
// path: an accepted pixel is registered in stage 1, updated from the state RAM read
// and registered in the output register; an output stall holds it in either register
// throughput: one pixel per cycle unless the output stalls, set by the one read
// and one write a cycle of the state RAM, forwarding when the same pixel follows directly
// reset: per-entry valid bits clear at once, so every pixel reads as zero;
// intensity resets to 255, speed_setting to 100; no clearing pass
module led_candle_flicker_engine_core #(
	parameter int unsigned PIXELS = lcf_pkg::PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [lcf_pkg::CFG_W-1:0]     cfg_wdata,
	lcf_in_if.sink                        pix_in,
	lcf_out_if.source                     lvl_out
);
	import lcf_pkg::*;

	// only indexes below both the pixel count and the index range are stored
	localparam int unsigned IDX_SPAN = 1 << IDX_W;
	localparam int unsigned DEPTH    = (PIXELS < IDX_SPAN) ? PIXELS : IDX_SPAN;
	localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [IDX_W:0] PIX_LIM = (IDX_W+1)'(DEPTH);

	logic [CFG_W-1:0] intensity_q, speed_q;

	logic               s1_v_q;
	logic [IDX_W-1:0]   idx_s1;
	logic               inr_s1;
	lcf_draws_t         draws_s1;
	logic               vld_s1;
	logic               fwd_hit_s1;
	lcf_entry_t         fwd_s1;

	logic [DEPTH-1:0]   valid_q;

	logic               out_v_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [LEVEL_W-1:0] out_lvl_q;

	logic               accept;
	logic               out_free;
	logic               s1_go;
	logic               wr_en;
	logic               in_range;
	logic [AW-1:0]      in_addr, s1_addr;
	logic [ENTRY_W-1:0] ram_rdata;
	lcf_entry_t         cur, nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q <= INTENSITY_RST;
			speed_q     <= SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTENSITY: intensity_q <= cfg_wdata;
				REG_SPEED:     speed_q     <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// handshake and flow control
	assign out_free     = !out_v_q || lvl_out.ready;
	assign s1_go        = s1_v_q && out_free;
	assign pix_in.ready = !s1_v_q || out_free;
	assign accept       = pix_in.valid && pix_in.ready;
	assign in_range     = ({1'b0, pix_in.pixel_index} < PIX_LIM);
	assign in_addr      = pix_in.pixel_index[AW-1:0];
	assign s1_addr      = idx_s1[AW-1:0];
	assign wr_en        = s1_go && inr_s1;

	// state memory
	lcf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (s1_addr),
		.wdata (nxt),
		.re    (accept && in_range),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// entry seen by the update: forwarded, stored, or reset value
	always_comb begin
		if (fwd_hit_s1)
			cur = fwd_s1;
		else if (vld_s1)
			cur = lcf_entry_t'(ram_rdata);
		else
			cur = '0;
	end

	lcf_tick_alu u_tick (
		.cur           (cur),
		.draws         (draws_s1),
		.intensity     (intensity_q),
		.speed_setting (speed_q),
		.nxt           (nxt)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v_q <= 1'b0;
		else if (pix_in.ready)
			s1_v_q <= pix_in.valid;
	end

	// stage 1 payload, forwarding when the pixel just written follows
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1               <= pix_in.pixel_index;
			inr_s1               <= in_range;
			draws_s1.init_draw   <= pix_in.init_draw;
			draws_s1.draw_first  <= pix_in.draw_first;
			draws_s1.draw_second <= pix_in.draw_second;
			draws_s1.draw_third  <= pix_in.draw_third;
			vld_s1               <= in_range && valid_q[in_addr];
			fwd_hit_s1           <= wr_en && (idx_s1 == pix_in.pixel_index);
			fwd_s1               <= nxt;
		end
	end

	// per-entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (wr_en)
			valid_q[s1_addr] <= 1'b1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_free)
			out_v_q <= s1_v_q;
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_idx_q <= idx_s1;
			out_lvl_q <= inr_s1 ? nxt.level : '0;
		end
	end

	assign lvl_out.valid            = out_v_q;
	assign lvl_out.pixel_out_index  = out_idx_q;
	assign lvl_out.brightness_level = out_lvl_q;

endmodule

[tb/flicker_level_checker.sv]
`timescale 1ns / 1ps
// flicker_level_checker: tracks every pixel's level, target and fade step and checks each result
// depends on lcf_pkg and the lcf_in_if / lcf_out_if channels; watches only, drives no channel signal
module flicker_level_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [lcf_pkg::CFG_W-1:0] cfg_wdata,
	lcf_in_if                         pix_in,
	lcf_out_if                        lvl_out,
	output int                        mismatch_count,
	output int                        pending
);
	import lcf_pkg::*;

	typedef struct {
		logic [IDX_W-1:0]   pixel;
		logic [LEVEL_W-1:0] level;
	} level_result_t;

	logic [LEVEL_W-1:0] level_q  [PIXELS_DEF];
	logic [LEVEL_W-1:0] target_q [PIXELS_DEF];
	logic [LEVEL_W-1:0] step_q   [PIXELS_DEF];
	logic [CFG_W-1:0]   intensity_q;
	logic [CFG_W-1:0]   speed_q;
	level_result_t      expected_levels [$];
	level_result_t      oldest;
	lcf_draws_t         draws;

	// right shift applied to the distance when a new fade step is formed
	function automatic int fade_shift(input logic [CFG_W-1:0] sp);
		if (sp > SPEED_FAST)
			return 1;
		if (sp > SPEED_MID)
			return 2;
		if (sp > SPEED_SLOW)
			return 3;
		return 4;
	endfunction

	// one flicker tick of one pixel; updates the stored entry, returns the new level
	function automatic logic [LEVEL_W-1:0] flicker_tick(input logic [IDX_W-1:0] px,
		input lcf_draws_t d);
		int lv;
		int tg;
		int st;
		int quarter;
		int delta;
		bit hit;
		lv = level_q[px];
		tg = target_q[px];
		st = step_q[px];
		// uninitialised pixel starts just below its first target
		if (st == 0) begin
			lv = LEVEL_INIT;
			tg = (int'(TARGET_BASE) + int'(d.init_draw)) & 255;
			st = 1;
		end
		// move toward the target, saturating at both ends
		if (tg > lv) begin
			lv = lv + st;
			if (lv > LEVEL_MAX)
				lv = LEVEL_MAX;
			hit = (lv >= tg);
		end else begin
			lv = (lv > st) ? lv - st : 0;
			hit = (lv <= tg);
		end
		// target reached: new target and fade step, all mod 256
		if (hit) begin
			quarter = int'(intensity_q) >> 2;
			tg = (int'(d.draw_first) + int'(d.draw_second)) & 255;
			if (tg < quarter)
				tg = (quarter + int'(d.draw_third)) & 255;
			tg = (tg + 255 - int'(intensity_q)) & 255;
			delta = (tg > lv) ? tg - lv : lv - tg;
			st = (delta >> fade_shift(speed_q)) & 255;
			if (st == 0)
				st = 1;
		end
		level_q[px]  = LEVEL_W'(lv);
		target_q[px] = LEVEL_W'(tg);
		step_q[px]   = LEVEL_W'(st);
		return LEVEL_W'(lv);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIXELS_DEF; i++) begin
				level_q[i]  = '0;
				target_q[i] = '0;
				step_q[i]   = '0;
			end
			intensity_q = INTENSITY_RST;
			speed_q = SPEED_RST;
			expected_levels.delete();
			mismatch_count = 0;
			pending = 0;
		end else begin
			// result transaction against the oldest expectation
			if (lvl_out.valid && lvl_out.ready) begin
				if (expected_levels.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with nothing expected, pixel %0d level %0d", $time,
						lvl_out.pixel_out_index, lvl_out.brightness_level);
				end else begin
					oldest = expected_levels.pop_front();
					if (lvl_out.pixel_out_index !== oldest.pixel) begin
						mismatch_count++;
						$display("%0t: pixel_out_index expected %0d, got %0d", $time,
							oldest.pixel, lvl_out.pixel_out_index);
					end
					if (lvl_out.brightness_level !== oldest.level) begin
						mismatch_count++;
						$display("%0t: brightness_level of pixel %0d expected %0d, got %0d",
							$time, oldest.pixel, oldest.level, lvl_out.brightness_level);
					end
				end
			end
			// input transaction: predict its level
			if (pix_in.valid && pix_in.ready) begin
				draws = {pix_in.init_draw, pix_in.draw_first, pix_in.draw_second,
					pix_in.draw_third};
				oldest.pixel = pix_in.pixel_index;
				oldest.level = flicker_tick(pix_in.pixel_index, draws);
				expected_levels.push_back(oldest);
			end
			// register write
			if (cfg_we) begin
				if (cfg_index == REG_INTENSITY)
					intensity_q = cfg_wdata;
				else if (cfg_index == REG_SPEED)
					speed_q = cfg_wdata;
			end
			pending = expected_levels.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: stimulus and verdict for led_candle_flicker_engine_core
// depends on lcf_pkg, lcf_in_if / lcf_out_if and flicker_level_checker
module tb;
	import lcf_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	int               mismatch_count;
	int               pending;
	int               cycle_count = 0;
	int               stall_left;
	bit               calm;

	lcf_in_if  pix_in ();
	lcf_out_if lvl_out ();

	led_candle_flicker_engine_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in),
		.lvl_out   (lvl_out)
	);

	flicker_level_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.pix_in         (pix_in),
		.lvl_out        (lvl_out),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[led_candle_flicker_engine_core] ERROR");
			$finish;
		end
	end

	// idle length: mostly short, now and then long
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// draw below half the intensity, with some out of range
	function automatic logic [DRAW_W-1:0] pick_draw(input logic [CFG_W-1:0] inten);
		int half;
		half = int'(inten) >> 1;
		if ($urandom_range(0, 99) < 15)
			return DRAW_W'($urandom_range(0, 127));
		if (half == 0)
			return '0;
		return DRAW_W'($urandom_range(0, half - 1));
	endfunction

	// output side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			lvl_out.ready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			lvl_out.ready <= 1'b0;
			stall_left = gap_len() - 1;
		end else begin
			lvl_out.ready <= 1'b1;
		end
	end

	// one pixel transaction, with an optional idle gap ahead of it
	task automatic send_tick(input logic [IDX_W-1:0] px, input lcf_draws_t d);
		int gap;
		gap = (calm || $urandom_range(0, 99) < 60) ? 0 : gap_len();
		if (gap > 0) begin
			@(negedge clk);
			pix_in.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_in.valid       <= 1'b1;
		pix_in.pixel_index <= px;
		pix_in.init_draw   <= d.init_draw;
		pix_in.draw_first  <= d.draw_first;
		pix_in.draw_second <= d.draw_second;
		pix_in.draw_third  <= d.draw_third;
		do
			@(posedge clk);
		while (!(pix_in.valid && pix_in.ready));
	endtask

	// stop sending and wait for every expected level to come out
	task automatic drain_results();
		@(negedge clk);
		pix_in.valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one register setting, then random ticks mostly on a few pixels
	task automatic run_phase(input logic [CFG_W-1:0] inten, input logic [CFG_W-1:0] speed,
		input int count, input bit quiet);
		lcf_draws_t       d;
		logic [IDX_W-1:0] px;
		write_reg(REG_INTENSITY, inten);
		write_reg(REG_SPEED, speed);
		calm = quiet;
		repeat (count) begin
			if ($urandom_range(0, 99) < 70)
				px = IDX_W'($urandom_range(0, 7));
			else
				px = IDX_W'($urandom_range(0, 63));
			d.init_draw   = INIT_W'($urandom_range(0, 3));
			d.draw_first  = pick_draw(inten);
			d.draw_second = pick_draw(inten);
			d.draw_third  = pick_draw(inten);
			send_tick(px, d);
		end
		drain_results();
	endtask

	initial begin
		lcf_draws_t d;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_INTENSITY;
		cfg_wdata          = '0;
		pix_in.valid       = 1'b0;
		pix_in.pixel_index = '0;
		pix_in.init_draw   = '0;
		pix_in.draw_first  = '0;
		pix_in.draw_second = '0;
		pix_in.draw_third  = '0;
		lvl_out.ready      = 1'b0;
		calm               = 1'b0;
		stall_left         = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first tick of fresh pixels, every initial offset
		for (int p = 0; p < 4; p++) begin
			d = '0;
			d.init_draw = INIT_W'(p);
			send_tick(IDX_W'(p), d);
		end
		// top pixel with all draws at their maximum
		d = '1;
		send_tick(IDX_W'(63), d);
		// both corner pixels until targets are reached, extreme draws alternating
		for (int k = 0; k < 16; k++) begin
			d = k[1] ? '1 : '0;
			send_tick(k[0] ? IDX_W'(63) : IDX_W'(0), d);
		end
		drain_results();

		// settings across the speed thresholds and the intensity extremes
		run_phase(8'd0, 8'd0, 90, 1'b0);
		run_phase(8'd255, 8'd255, 100, 1'b1);
		run_phase(8'd1, 8'd253, 90, 1'b0);
		run_phase(8'd2, 8'd252, 90, 1'b0);
		run_phase(8'd128, 8'd50, 100, 1'b0);
		run_phase(8'd200, 8'd99, 90, 1'b1);
		run_phase(8'd100, 8'd49, 90, 1'b0);
		run_phase(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)), 100, 1'b0);
		run_phase(8'd255, 8'd100, 100, 1'b0);

		if (mismatch_count == 0)
			$display("[led_candle_flicker_engine_core] OK");
		else
			$display("[led_candle_flicker_engine_core] ERROR");
		$finish;
	end

endmodule
